@@ rtl/spau_pkg.sv @@
`default_nettype none

package spau_pkg;

  localparam int unsigned TileCount     = 1024;
  localparam int unsigned ScreenWidth   = 240;
  localparam int unsigned ScreenHeight  = 160;
  localparam int unsigned TileRowStride = 32;

  localparam int unsigned DimW   = 7;
  localparam int unsigned PosXW  = 9;
  localparam int unsigned PosYW  = 8;
  localparam int unsigned PixW   = 6;
  localparam int unsigned TexelW = 3;

  typedef enum logic [1:0] {
    SHAPE_SQUARE = 2'd0,
    SHAPE_WIDE   = 2'd1,
    SHAPE_TALL   = 2'd2
  } shape_e;

  typedef logic [DimW-1:0] dim_t;

  // square dimension for a size index
  function automatic dim_t square_dim(input logic [1:0] size);
    dim_t d;
    case (size)
      2'd0:    d = 7'd8;
      2'd1:    d = 7'd16;
      2'd2:    d = 7'd32;
      default: d = 7'd64;
    endcase
    return d;
  endfunction

  // long side of a wide or tall sprite
  function automatic dim_t long_dim(input logic [1:0] size);
    dim_t d;
    case (size)
      2'd0:    d = 7'd16;
      2'd1:    d = 7'd32;
      2'd2:    d = 7'd32;
      default: d = 7'd64;
    endcase
    return d;
  endfunction

  // short side of a wide or tall sprite
  function automatic dim_t short_dim(input logic [1:0] size);
    dim_t d;
    case (size)
      2'd0:    d = 7'd8;
      2'd1:    d = 7'd8;
      2'd2:    d = 7'd16;
      default: d = 7'd32;
    endcase
    return d;
  endfunction

  // the prohibited shape code decodes as square
  function automatic dim_t sprite_dim_w(input logic [1:0] shape, input logic [1:0] size);
    dim_t d;
    case (shape)
      SHAPE_WIDE: d = long_dim(size);
      SHAPE_TALL: d = short_dim(size);
      default:    d = square_dim(size);
    endcase
    return d;
  endfunction

  function automatic dim_t sprite_dim_h(input logic [1:0] shape, input logic [1:0] size);
    dim_t d;
    case (shape)
      SHAPE_WIDE: d = short_dim(size);
      SHAPE_TALL: d = long_dim(size);
      default:    d = square_dim(size);
    endcase
    return d;
  endfunction

endpackage

`default_nettype wire

@@ rtl/spau_req_if.sv @@
`default_nettype none

interface spau_req_if #(
  parameter int unsigned TILE_W = 10
);
  logic              valid;
  logic              ready;
  logic [1:0]        shape_sel;
  logic [1:0]        size_sel;
  logic [TILE_W-1:0] tile_base;
  logic              affine;
  logic              hflip;
  logic              vflip;
  logic              hidden;
  logic [8:0]        sprite_x;
  logic [7:0]        sprite_y;
  logic [5:0]        pix_col;
  logic [5:0]        pix_row;

  modport source (
    output valid, shape_sel, size_sel, tile_base, affine, hflip, vflip, hidden,
           sprite_x, sprite_y, pix_col, pix_row,
    input  ready
  );

  modport sink (
    input  valid, shape_sel, size_sel, tile_base, affine, hflip, vflip, hidden,
           sprite_x, sprite_y, pix_col, pix_row,
    output ready
  );
endinterface

`default_nettype wire

@@ rtl/spau_rsp_if.sv @@
`default_nettype none

interface spau_rsp_if #(
  parameter int unsigned TILE_W = 10,
  parameter int unsigned SX_W   = 8,
  parameter int unsigned SY_W   = 8
);
  logic              valid;
  logic              ready;
  logic              draw;
  logic [SX_W-1:0]   screen_x;
  logic [SY_W-1:0]   screen_y;
  logic [TILE_W-1:0] tile_index;
  logic [2:0]        texel_col;
  logic [2:0]        texel_row;
  logic [6:0]        sprite_width;
  logic [6:0]        sprite_height;

  modport source (
    output valid, draw, screen_x, screen_y, tile_index, texel_col, texel_row,
           sprite_width, sprite_height,
    input  ready
  );

  modport sink (
    input  valid, draw, screen_x, screen_y, tile_index, texel_col, texel_row,
           sprite_width, sprite_height,
    output ready
  );
endinterface

`default_nettype wire

@@ rtl/sprite_pixel_address_unit.sv @@
// sprite pixel address unit
// req_i (valid/ready) carries one sprite's attributes and a pixel position inside
// the sprite; rsp_o (valid/ready) returns draw, screen coordinates, tile number,
// texel within the tile and the sprite size for that pixel.
// cfg_we_i/cfg_wdata_i write the one_d_mapping bit; write it only while the unit
// is empty.
// a request taken is held in the input register, its response in the response
// register, with the address logic between the input and response registers.
// throughput: one request per cycle, held by the single input and output register
// pair; both advance together whenever the response register is empty or taken.
// a stalled response holds its register and the input register keeps one more
// request, so req_i.ready drops only when both are full and rsp_o.ready is low.
// reset clears both valid flags and one_d_mapping; no response is pending after it.
// TILE_COUNT is taken to be a power of two, the tile number wraps at it.
`default_nettype none

module sprite_pixel_address_unit import spau_pkg::*; #(
  parameter int unsigned TILE_COUNT      = TileCount,
  parameter int unsigned SCREEN_WIDTH    = ScreenWidth,
  parameter int unsigned SCREEN_HEIGHT   = ScreenHeight,
  parameter int unsigned TILE_ROW_STRIDE = TileRowStride
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   cfg_we_i,
  input  wire logic   cfg_wdata_i,
  spau_req_if.sink    req_i,
  spau_rsp_if.source  rsp_o
);

  localparam int unsigned TileW = $clog2(TILE_COUNT);
  localparam int unsigned SxW   = $clog2(SCREEN_WIDTH);
  localparam int unsigned SyW   = $clog2(SCREEN_HEIGHT);

  logic one_d_mapping_q;

  logic              in_valid_q;
  logic [1:0]        shape_q, size_q;
  logic [TileW-1:0]  base_q;
  logic              affine_q, hflip_q, vflip_q, hidden_q;
  logic [PosXW-1:0]  sx_q;
  logic [PosYW-1:0]  sy_q;
  logic [PixW-1:0]   col_q, row_q;

  logic              out_valid_q;
  logic              draw_q, draw_d;
  logic [SxW-1:0]    screen_x_q, screen_x_d;
  logic [SyW-1:0]    screen_y_q, screen_y_d;
  logic [TileW-1:0]  tile_q, tile_d;
  logic [TexelW-1:0] texel_col_q, texel_col_d, texel_row_q, texel_row_d;
  dim_t              width_q, height_q;

  logic req_fire, stage_fire;

  dim_t             w, h;
  logic [PosXW:0]   px;
  logic [PosYW:0]   py;
  logic [PixW-1:0]  c, r;
  logic [6:0]       row_off_1d;
  logic [9:0]       row_off_2d;
  logic [TileW-1:0] row_off;

  assign stage_fire  = in_valid_q && (!out_valid_q || rsp_o.ready);
  assign req_i.ready = !in_valid_q || stage_fire;
  assign req_fire    = req_i.valid && req_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      one_d_mapping_q <= 1'b0;
    end else if (cfg_we_i) begin
      one_d_mapping_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (req_fire) begin
      in_valid_q <= 1'b1;
    end else if (stage_fire) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      shape_q  <= req_i.shape_sel;
      size_q   <= req_i.size_sel;
      base_q   <= req_i.tile_base;
      affine_q <= req_i.affine;
      hflip_q  <= req_i.hflip;
      vflip_q  <= req_i.vflip;
      hidden_q <= req_i.hidden;
      sx_q     <= req_i.sprite_x;
      sy_q     <= req_i.sprite_y;
      col_q    <= req_i.pix_col;
      row_q    <= req_i.pix_row;
    end
  end

  always_comb begin
    w  = sprite_dim_w(shape_q, size_q);
    h  = sprite_dim_h(shape_q, size_q);
    px = {1'b0, sx_q} + (PosXW+1)'(col_q);
    py = {1'b0, sy_q} + (PosYW+1)'(row_q);

    draw_d = !hidden_q
          && ({1'b0, col_q} < w) && ({1'b0, row_q} < h)
          && (px < (PosXW+1)'(SCREEN_WIDTH)) && (py < (PosYW+1)'(SCREEN_HEIGHT));

    // flips only outside affine mode
    c = col_q;
    r = row_q;
    if (!affine_q && hflip_q) begin
      c = PixW'(w - 7'd1 - {1'b0, col_q});
    end
    if (!affine_q && vflip_q) begin
      r = PixW'(h - 7'd1 - {1'b0, row_q});
    end

    row_off_1d = 7'(r[5:3]) * 7'(w[6:3]);
    row_off_2d = 10'(r[5:3]) * 10'(TILE_ROW_STRIDE);
    row_off    = one_d_mapping_q ? TileW'(row_off_1d) : TileW'(row_off_2d);

    screen_x_d  = '0;
    screen_y_d  = '0;
    tile_d      = '0;
    texel_col_d = '0;
    texel_row_d = '0;
    if (draw_d) begin
      screen_x_d  = SxW'(px);
      screen_y_d  = SyW'(py);
      tile_d      = base_q + row_off + TileW'(c[5:3]);
      texel_col_d = c[2:0];
      texel_row_d = r[2:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (stage_fire) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (stage_fire) begin
      draw_q      <= draw_d;
      screen_x_q  <= screen_x_d;
      screen_y_q  <= screen_y_d;
      tile_q      <= tile_d;
      texel_col_q <= texel_col_d;
      texel_row_q <= texel_row_d;
      width_q     <= w;
      height_q    <= h;
    end
  end

  assign rsp_o.valid         = out_valid_q;
  assign rsp_o.draw          = draw_q;
  assign rsp_o.screen_x      = screen_x_q;
  assign rsp_o.screen_y      = screen_y_q;
  assign rsp_o.tile_index    = tile_q;
  assign rsp_o.texel_col     = texel_col_q;
  assign rsp_o.texel_row     = texel_row_q;
  assign rsp_o.sprite_width  = width_q;
  assign rsp_o.sprite_height = height_q;

endmodule

`default_nettype wire

@@ rtl/spau_checker.sv @@
`default_nettype none

module spau_checker #(
  parameter int unsigned TILE_W        = 10,
  parameter int unsigned SX_W          = 8,
  parameter int unsigned SY_W          = 8,
  parameter int unsigned SCREEN_WIDTH  = 240,
  parameter int unsigned SCREEN_HEIGHT = 160
) (
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              rsp_valid_i,
  input wire logic              rsp_ready_i,
  input wire logic              draw_i,
  input wire logic [SX_W-1:0]   screen_x_i,
  input wire logic [SY_W-1:0]   screen_y_i,
  input wire logic [TILE_W-1:0] tile_index_i,
  input wire logic [2:0]        texel_col_i,
  input wire logic [2:0]        texel_row_i,
  input wire logic [6:0]        sprite_width_i,
  input wire logic [6:0]        sprite_height_i
);

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i)
    else $error("response dropped while stalled");

  // a pixel not drawn carries zero address fields
  a_blank: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !draw_i |-> screen_x_i == '0 && screen_y_i == '0
      && tile_index_i == '0 && texel_col_i == '0 && texel_row_i == '0)
    else $error("address fields set on a pixel not drawn");

  a_on_screen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && draw_i |-> screen_x_i < SCREEN_WIDTH && screen_y_i < SCREEN_HEIGHT)
    else $error("drawn pixel off screen");

  a_dims: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> $onehot(sprite_width_i) && $onehot(sprite_height_i)
      && sprite_width_i >= 7'd8 && sprite_height_i >= 7'd8
      && sprite_width_i <= 7'd64 && sprite_height_i <= 7'd64)
    else $error("sprite size not a table entry");

endmodule

bind sprite_pixel_address_unit spau_checker #(
  .TILE_W        (TileW),
  .SX_W          (SxW),
  .SY_W          (SyW),
  .SCREEN_WIDTH  (SCREEN_WIDTH),
  .SCREEN_HEIGHT (SCREEN_HEIGHT)
) u_spau_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .rsp_valid_i     (rsp_o.valid),
  .rsp_ready_i     (rsp_o.ready),
  .draw_i          (rsp_o.draw),
  .screen_x_i      (rsp_o.screen_x),
  .screen_y_i      (rsp_o.screen_y),
  .tile_index_i    (rsp_o.tile_index),
  .texel_col_i     (rsp_o.texel_col),
  .texel_row_i     (rsp_o.texel_row),
  .sprite_width_i  (rsp_o.sprite_width),
  .sprite_height_i (rsp_o.sprite_height)
);

`default_nettype wire

@@ tb/tb_sprite_pixel_address_unit.sv @@
`timescale 1ns / 100ps

module tb_sprite_pixel_address_unit;
  import spau_pkg::*;

  localparam logic [1:0] SHAPE_PROHIBITED = 2'd3;
  localparam int unsigned CycleLimit = 100000;
  localparam int unsigned RandomPerPhase = 300;

  typedef struct packed {
    logic [1:0] shape;
    logic [1:0] size;
    logic [9:0] tile_base;
    logic       affine;
    logic       hflip;
    logic       vflip;
    logic       hidden;
    logic [8:0] sx;
    logic [7:0] sy;
    logic [5:0] col;
    logic [5:0] row;
  } sprite_req_t;

  typedef struct packed {
    logic       draw;
    logic [7:0] screen_x;
    logic [7:0] screen_y;
    logic [9:0] tile_index;
    logic [2:0] texel_col;
    logic [2:0] texel_row;
    logic [6:0] width;
    logic [6:0] height;
  } pixel_rsp_t;

  class pixel_address_scoreboard;
    pixel_rsp_t  pending_addrs[$];
    bit          linear_tiles;
    int unsigned errors;
    int unsigned requests;
    int unsigned drawn;

    function new();
      linear_tiles = 1'b0;
      errors = 0;
      requests = 0;
      drawn = 0;
    endfunction

    static function void sprite_dims(input logic [1:0] shape, input logic [1:0] size,
                                     output int unsigned w, output int unsigned h);
      int unsigned lng;
      int unsigned shrt;
      lng  = (size == 2'd0) ? 16 : (size == 2'd3) ? 64 : 32;
      shrt = (size == 2'd3) ? 32 : (size == 2'd2) ? 16 : 8;
      case (shape_e'(shape))
        SHAPE_WIDE: begin
          w = lng;
          h = shrt;
        end
        SHAPE_TALL: begin
          w = shrt;
          h = lng;
        end
        default: begin
          w = 8 << size;
          h = 8 << size;
        end
      endcase
    endfunction

    function pixel_rsp_t map_pixel(input sprite_req_t r);
      pixel_rsp_t  o;
      int unsigned w, h, px, py, col, row, c, rw, tile;
      bit          on;
      sprite_dims(r.shape, r.size, w, h);
      col = 32'(r.col);
      row = 32'(r.row);
      px = 32'(r.sx) + col;
      py = 32'(r.sy) + row;
      o = '0;
      o.width  = 7'(w);
      o.height = 7'(h);
      on = !r.hidden && col < w && row < h && px < ScreenWidth && py < ScreenHeight;
      if (on) begin
        c  = col;
        rw = row;
        // flips only matter outside rotation/scaling mode
        if (!r.affine) begin
          if (r.hflip) c = w - 1 - col;
          if (r.vflip) rw = h - 1 - row;
        end
        if (linear_tiles) tile = 32'(r.tile_base) + (rw >> 3) * (w >> 3) + (c >> 3);
        else tile = 32'(r.tile_base) + (rw >> 3) * TileRowStride + (c >> 3);
        o.draw       = 1'b1;
        o.screen_x   = 8'(px);
        o.screen_y   = 8'(py);
        o.tile_index = 10'(tile % TileCount);
        o.texel_col  = 3'(c & 7);
        o.texel_row  = 3'(rw & 7);
      end
      return o;
    endfunction

    function void take_request(input sprite_req_t r);
      pending_addrs = {pending_addrs, map_pixel(r)};
      requests++;
    endfunction

    function void check_field(input string name, input int unsigned exp_v,
                              input int unsigned act_v);
      if (exp_v != act_v) begin
        $error("%s: expected %0d, got %0d", name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_response(input pixel_rsp_t got);
      pixel_rsp_t want;
      if (pending_addrs.size() == 0) begin
        $error("response with no request outstanding");
        errors++;
        return;
      end
      want = pending_addrs.pop_front();
      if (want.draw) drawn++;
      check_field("draw", 32'(want.draw), 32'(got.draw));
      check_field("screen_x", 32'(want.screen_x), 32'(got.screen_x));
      check_field("screen_y", 32'(want.screen_y), 32'(got.screen_y));
      check_field("tile_index", 32'(want.tile_index), 32'(got.tile_index));
      check_field("texel_col", 32'(want.texel_col), 32'(got.texel_col));
      check_field("texel_row", 32'(want.texel_row), 32'(got.texel_row));
      check_field("sprite_width", 32'(want.width), 32'(got.width));
      check_field("sprite_height", 32'(want.height), 32'(got.height));
    endfunction

    function int unsigned pending();
      return pending_addrs.size();
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we;
  logic cfg_wdata;

  int unsigned gap_pct;
  int unsigned stall_pct;
  int unsigned hold_left;
  int unsigned cycle_count = 0;

  pixel_address_scoreboard addr_sb;

  spau_req_if req ();
  spau_rsp_if rsp ();

  sprite_pixel_address_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .req_i       (req),
    .rsp_o       (rsp)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // response side: long hold-off first, otherwise random stalls
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      rsp.ready <= 1'b0;
    end else if (hold_left > 0) begin
      rsp.ready <= 1'b0;
      hold_left--;
    end else begin
      rsp.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (req.valid && req.ready)
        addr_sb.take_request({req.shape_sel, req.size_sel, req.tile_base, req.affine,
                              req.hflip, req.vflip, req.hidden, req.sprite_x,
                              req.sprite_y, req.pix_col, req.pix_row});
      if (rsp.valid && rsp.ready)
        addr_sb.check_response({rsp.draw, rsp.screen_x, rsp.screen_y, rsp.tile_index,
                                rsp.texel_col, rsp.texel_row, rsp.sprite_width,
                                rsp.sprite_height});
    end
  end

  function automatic sprite_req_t make_req(input logic [1:0] shape, input logic [1:0] size,
                                           input logic [9:0] base, input logic aff,
                                           input logic hf, input logic vf,
                                           input logic hid, input logic [8:0] sx,
                                           input logic [7:0] sy, input logic [5:0] col,
                                           input logic [5:0] row);
    sprite_req_t r;
    r = {shape, size, base, aff, hf, vf, hid, sx, sy, col, row};
    return r;
  endfunction

  // mostly sprites that land on screen, the rest fully random
  function automatic sprite_req_t random_request();
    sprite_req_t r;
    int unsigned w, h;
    r = sprite_req_t'({$urandom, $urandom});
    if ($urandom_range(99) < 80) begin
      r.shape = 2'($urandom_range(SHAPE_SQUARE, SHAPE_TALL));
      pixel_address_scoreboard::sprite_dims(r.shape, r.size, w, h);
      r.col    = 6'($urandom_range(0, w - 1));
      r.row    = 6'($urandom_range(0, h - 1));
      r.sx     = 9'($urandom_range(0, ScreenWidth - 1));
      r.sy     = 8'($urandom_range(0, ScreenHeight - 1));
      r.hidden = ($urandom_range(15) == 0);
    end
    return r;
  endfunction

  task automatic send_req(input sprite_req_t r);
    @(negedge clk_i);
    while ($urandom_range(99) < gap_pct) begin
      req.valid <= 1'b0;
      @(negedge clk_i);
    end
    req.valid     <= 1'b1;
    req.shape_sel <= r.shape;
    req.size_sel  <= r.size;
    req.tile_base <= r.tile_base;
    req.affine    <= r.affine;
    req.hflip     <= r.hflip;
    req.vflip     <= r.vflip;
    req.hidden    <= r.hidden;
    req.sprite_x  <= r.sx;
    req.sprite_y  <= r.sy;
    req.pix_col   <= r.col;
    req.pix_row   <= r.row;
    do @(posedge clk_i); while (!req.ready);
  endtask

  task automatic drain_requests();
    @(negedge clk_i);
    req.valid <= 1'b0;
    while (addr_sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_tile_layout(input bit linear);
    drain_requests();
    @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= linear;
    @(negedge clk_i);
    cfg_we    <= 1'b0;
    addr_sb.linear_tiles = linear;
  endtask

  initial begin
    sprite_req_t directed[$];
    int unsigned phase_gap[4];
    int unsigned phase_stall[4];

    addr_sb = new();
    rst_ni = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = 1'b0;
    req.valid = 1'b0;
    req.shape_sel = '0;
    req.size_sel = '0;
    req.tile_base = '0;
    req.affine = 1'b0;
    req.hflip = 1'b0;
    req.vflip = 1'b0;
    req.hidden = 1'b0;
    req.sprite_x = '0;
    req.sprite_y = '0;
    req.pix_col = '0;
    req.pix_row = '0;
    rsp.ready = 1'b0;
    gap_pct = 0;
    stall_pct = 0;
    hold_left = 0;
    phase_gap   = '{0, 50, 0, 28};
    phase_stall = '{0, 0, 50, 28};

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed corners, two-dimensional layout from reset
    directed = '{
      make_req(SHAPE_SQUARE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0),
      make_req(SHAPE_SQUARE, 3, 1023, 0, 0, 0, 0, 0, 0, 63, 63),
      make_req(SHAPE_WIDE, 0, 10, 0, 1, 0, 0, 100, 50, 15, 7),
      make_req(SHAPE_TALL, 0, 20, 0, 0, 1, 0, 100, 50, 7, 15),
      make_req(SHAPE_TALL, 3, 1000, 0, 1, 1, 0, 8, 8, 5, 40),
      make_req(SHAPE_SQUARE, 2, 33, 1, 1, 1, 0, 40, 40, 3, 20),
      make_req(SHAPE_SQUARE, 1, 5, 0, 0, 0, 1, 10, 10, 1, 1),
      make_req(SHAPE_SQUARE, 0, 5, 0, 0, 0, 0, 10, 10, 8, 0),
      make_req(SHAPE_WIDE, 0, 5, 0, 0, 0, 0, 10, 10, 0, 8),
      make_req(SHAPE_SQUARE, 0, 5, 0, 0, 0, 0, 511, 0, 0, 0),
      make_req(SHAPE_SQUARE, 0, 5, 0, 0, 0, 0, 0, 255, 0, 0),
      make_req(SHAPE_SQUARE, 0, 7, 0, 0, 0, 0, 232, 0, 7, 0),
      make_req(SHAPE_SQUARE, 0, 7, 0, 0, 0, 0, 233, 0, 7, 0),
      make_req(SHAPE_SQUARE, 0, 7, 0, 0, 0, 0, 0, 152, 0, 7),
      make_req(SHAPE_SQUARE, 0, 7, 0, 0, 0, 0, 0, 153, 0, 7),
      make_req(SHAPE_PROHIBITED, 2, 100, 0, 1, 0, 0, 0, 0, 31, 31),
      make_req(SHAPE_PROHIBITED, 3, 100, 0, 0, 1, 0, 0, 0, 63, 63),
      make_req(SHAPE_WIDE, 3, 1000, 0, 1, 0, 0, 100, 120, 63, 31),
      make_req(SHAPE_TALL, 2, 990, 0, 0, 1, 0, 200, 100, 15, 31),
      make_req(SHAPE_PROHIBITED, 3, 1023, 1, 1, 1, 1, 511, 255, 63, 63)
    };
    foreach (directed[i]) send_req(directed[i]);

    for (int p = 0; p < 4; p++) begin
      set_tile_layout(p % 2 == 0);
      gap_pct   = phase_gap[p];
      stall_pct = phase_stall[p];
      for (int i = 0; i < RandomPerPhase; i++) begin
        if (p == 0 && i == 100) begin
          // receiver stops while requests keep coming, so the unit backs up
          hold_left = 60;
        end
        if (p == 0 && i == 200) drain_requests();
        send_req(random_request());
      end
    end

    drain_requests();
    $display("covered %0d requests, %0d drawn, both tile layouts, four idle/stall mixes",
             addr_sb.requests, addr_sb.drawn);
    if (addr_sb.errors == 0 && addr_sb.pending() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches, %0d responses missing", addr_sb.errors, addr_sb.pending());
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
